FILE: hdl/tce_pkg.sv
package tce_pkg;

    localparam int NUM_SLOTS = 10;

    // byte positions within one tick, in transmit order
    localparam int SLOT_PAN_CODE  = 0;
    localparam int SLOT_PAN_VAL   = 1;
    localparam int SLOT_TILT_CODE = 2;
    localparam int SLOT_TILT_VAL  = 3;
    localparam int SLOT_VEL_CODE  = 4;
    localparam int SLOT_VEL_VAL   = 5;
    localparam int SLOT_ROT_CODE  = 6;
    localparam int SLOT_ROT_VAL   = 7;
    localparam int SLOT_HALT      = 8;
    localparam int SLOT_BEAM      = 9;

    localparam logic [7:0] CENTRE = 8'd127;

    localparam logic [6:0] DEADZONE_RST      = 7'd31;
    localparam logic [7:0] PAN_CODE_RST      = 8'd1;
    localparam logic [7:0] TILT_CODE_RST     = 8'd2;
    localparam logic [7:0] VEL_CODE_RST      = 8'd3;
    localparam logic [7:0] ROT_CODE_RST      = 8'd4;
    localparam logic [7:0] HALT_CODE_RST     = 8'd5;
    localparam logic [7:0] BEAM_ON_CODE_RST  = 8'd6;
    localparam logic [7:0] BEAM_OFF_CODE_RST = 8'd7;

    typedef enum logic [2:0] {
        CFG_DEADZONE      = 3'd0,
        CFG_PAN_CODE      = 3'd1,
        CFG_TILT_CODE     = 3'd2,
        CFG_VEL_CODE      = 3'd3,
        CFG_ROT_CODE      = 3'd4,
        CFG_HALT_CODE     = 3'd5,
        CFG_BEAM_ON_CODE  = 3'd6,
        CFG_BEAM_OFF_CODE = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DRIVE_STOPPED  = 2'd0,
        DRIVE_MOVING   = 2'd1,
        DRIVE_STOPPING = 2'd2
    } t_drive;

    typedef enum logic [1:0] {
        BEAM_UP_ACKED   = 2'd0,
        BEAM_DOWN_WAIT  = 2'd1,
        BEAM_DOWN_ACKED = 2'd2,
        BEAM_UP_WAIT    = 2'd3
    } t_beam;

    typedef struct packed {
        logic [7:0] pan;
        logic [7:0] tilt;
        logic [7:0] vel;
        logic [7:0] rot;
        logic [7:0] halt;
        logic [7:0] beam_on;
        logic [7:0] beam_off;
    } t_codes;

    // one tick's worth of work for the back end
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [7:0]           pan;
        logic [7:0]           tilt;
        logic [7:0]           vel;
        logic [7:0]           rot;
        logic                 beam_off;
    } t_rec;

    function automatic logic outside(input logic [7:0] v, input logic [6:0] dz);
        logic [8:0] hi;
        logic [8:0] lo_sum;
        hi     = {1'b0, CENTRE} + {2'b00, dz};
        lo_sum = {1'b0, v} + {2'b00, dz};
        return ({1'b0, v} > hi) || (lo_sum < {1'b0, CENTRE});
    endfunction

endpackage

FILE: hdl/teleop_command_encoder_ack.sv
// remote-control command encoder with acknowledgement handling
//
// input channel (i_valid / o_stall): one transaction is either a sample tick
// (i_action low: four stick samples and the button level) or a received byte
// (i_action high: i_received_byte acknowledges a halt or laser command).
// output channel (o_valid / i_stall): one command or value byte per
// transaction, o_last_of_run marks the final byte of a tick. a quiet tick or
// a received byte produces no output.
// config channel (i_cfg_valid / o_cfg_ready): always ready, one register per
// transaction; write only while the block is idle.
//
// the front end classifies a tick in the cycle it is taken and queues one
// record; the back end sends one byte per cycle from it while i_stall is
// low. first byte of a tick passes the queue, back end mask and output
// registers; a tick holds the back end for up to nine bytes. inputs are
// taken every cycle while the record queue (QUEUE_DEPTH entries) has room.
// i_stall holds the output register; the back end then stops, the queue
// fills and o_stall rises. reset empties the queue, returns drive and laser
// state to stopped / button up acknowledged and loads the default codes.
module teleop_command_encoder_ack #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [9:0] i_pan_sample,
    input  logic [9:0] i_tilt_sample,
    input  logic [9:0] i_rotation_sample,
    input  logic [9:0] i_velocity_sample,
    input  logic       i_button_released,
    input  logic [7:0] i_received_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_tx_byte,
    output logic       o_last_of_run,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic            [6:0] r_deadzone;
    tce_pkg::t_codes       r_codes;

    logic            w_accept, w_push, w_pop, w_q_full, w_q_valid;
    tce_pkg::t_rec   w_push_rec, w_q_rec;
    tce_pkg::t_drive w_drive;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = w_q_full;
    assign w_accept    = i_valid && !w_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone       <= tce_pkg::DEADZONE_RST;
            r_codes.pan      <= tce_pkg::PAN_CODE_RST;
            r_codes.tilt     <= tce_pkg::TILT_CODE_RST;
            r_codes.vel      <= tce_pkg::VEL_CODE_RST;
            r_codes.rot      <= tce_pkg::ROT_CODE_RST;
            r_codes.halt     <= tce_pkg::HALT_CODE_RST;
            r_codes.beam_on  <= tce_pkg::BEAM_ON_CODE_RST;
            r_codes.beam_off <= tce_pkg::BEAM_OFF_CODE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (tce_pkg::t_cfg_idx'(i_cfg_index))
                tce_pkg::CFG_DEADZONE:      r_deadzone       <= i_cfg_data[6:0];
                tce_pkg::CFG_PAN_CODE:      r_codes.pan      <= i_cfg_data;
                tce_pkg::CFG_TILT_CODE:     r_codes.tilt     <= i_cfg_data;
                tce_pkg::CFG_VEL_CODE:      r_codes.vel      <= i_cfg_data;
                tce_pkg::CFG_ROT_CODE:      r_codes.rot      <= i_cfg_data;
                tce_pkg::CFG_HALT_CODE:     r_codes.halt     <= i_cfg_data;
                tce_pkg::CFG_BEAM_ON_CODE:  r_codes.beam_on  <= i_cfg_data;
                tce_pkg::CFG_BEAM_OFF_CODE: r_codes.beam_off <= i_cfg_data;
                default: r_deadzone <= r_deadzone;
            endcase
        end
    end

    tce_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (w_accept),
        .i_action          (i_action),
        .i_pan_sample      (i_pan_sample),
        .i_tilt_sample     (i_tilt_sample),
        .i_rotation_sample (i_rotation_sample),
        .i_velocity_sample (i_velocity_sample),
        .i_button_released (i_button_released),
        .i_received_byte   (i_received_byte),
        .i_deadzone        (r_deadzone),
        .i_codes           (r_codes),
        .o_push            (w_push),
        .o_rec             (w_push_rec),
        .o_drive           (w_drive)
    );

    tce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_rec   (w_q_rec)
    );

    tce_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_rec       (w_q_rec),
        .i_codes       (r_codes),
        .i_stall       (i_stall),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .o_tx_byte     (o_tx_byte),
        .o_last_of_run (o_last_of_run)
    );

    // a queued halt means the drive is waiting for its acknowledgement
    a_halt_means_stopping: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_push_rec.mask[tce_pkg::SLOT_HALT]) |=> (w_drive == tce_pkg::DRIVE_STOPPING))
        else $error("halt queued without entering stopping");

    a_no_empty_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_push_rec.mask != '0))
        else $error("empty record queued");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty queue");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("push into full queue");

endmodule

FILE: hdl/tce_front.sv
module tce_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_action,
    input  logic [9:0]          i_pan_sample,
    input  logic [9:0]          i_tilt_sample,
    input  logic [9:0]          i_rotation_sample,
    input  logic [9:0]          i_velocity_sample,
    input  logic                i_button_released,
    input  logic [7:0]          i_received_byte,
    input  logic [6:0]          i_deadzone,
    input  tce_pkg::t_codes     i_codes,
    output logic                o_push,
    output tce_pkg::t_rec       o_rec,
    output tce_pkg::t_drive     o_drive
);

    tce_pkg::t_drive r_drive, n_drive;
    tce_pkg::t_beam  r_beam,  n_beam;

    logic [7:0] w_pan, w_tilt, w_rot, w_vel;
    logic       w_pan_out, w_tilt_out, w_rot_out, w_vel_out, w_moving;

    assign w_pan  = i_pan_sample[9:2];
    assign w_tilt = i_tilt_sample[9:2];
    assign w_rot  = i_rotation_sample[9:2];
    assign w_vel  = i_velocity_sample[9:2];

    assign w_pan_out  = tce_pkg::outside(w_pan, i_deadzone);
    assign w_tilt_out = tce_pkg::outside(w_tilt, i_deadzone);
    assign w_rot_out  = tce_pkg::outside(w_rot, i_deadzone);
    assign w_vel_out  = tce_pkg::outside(w_vel, i_deadzone);
    assign w_moving   = w_rot_out || w_vel_out;

    // next state
    always_comb begin
        n_drive = r_drive;
        n_beam  = r_beam;
        if (i_accept) begin
            if (i_action) begin
                // first matching code wins, even if its ack is not awaited
                if (i_received_byte == i_codes.beam_on) begin
                    if (r_beam == tce_pkg::BEAM_DOWN_WAIT) n_beam = tce_pkg::BEAM_DOWN_ACKED;
                end else if (i_received_byte == i_codes.beam_off) begin
                    if (r_beam == tce_pkg::BEAM_UP_WAIT) n_beam = tce_pkg::BEAM_UP_ACKED;
                end else if (i_received_byte == i_codes.halt) begin
                    if (r_drive == tce_pkg::DRIVE_STOPPING) n_drive = tce_pkg::DRIVE_STOPPED;
                end
            end else begin
                case (r_drive)
                    tce_pkg::DRIVE_STOPPING: n_drive = tce_pkg::DRIVE_STOPPING;
                    tce_pkg::DRIVE_MOVING: begin
                        n_drive = w_moving ? tce_pkg::DRIVE_MOVING : tce_pkg::DRIVE_STOPPING;
                    end
                    default: begin
                        if (w_moving) n_drive = tce_pkg::DRIVE_MOVING;
                    end
                endcase
                case (r_beam)
                    tce_pkg::BEAM_DOWN_ACKED: begin
                        if (i_button_released) n_beam = tce_pkg::BEAM_UP_WAIT;
                    end
                    tce_pkg::BEAM_UP_ACKED: begin
                        if (!i_button_released) n_beam = tce_pkg::BEAM_DOWN_WAIT;
                    end
                    default: n_beam = r_beam;
                endcase
            end
        end
    end

    // record for the back end
    always_comb begin
        o_rec          = '0;
        o_rec.pan      = w_pan;
        o_rec.tilt     = w_tilt;
        o_rec.vel      = w_vel;
        o_rec.rot      = w_rot;
        o_rec.mask[tce_pkg::SLOT_PAN_CODE]  = w_pan_out;
        o_rec.mask[tce_pkg::SLOT_PAN_VAL]   = w_pan_out;
        o_rec.mask[tce_pkg::SLOT_TILT_CODE] = w_tilt_out;
        o_rec.mask[tce_pkg::SLOT_TILT_VAL]  = w_tilt_out;
        if (r_drive == tce_pkg::DRIVE_STOPPING) begin
            // drive sticks ignored while the halt is resent
            o_rec.mask[tce_pkg::SLOT_HALT] = 1'b1;
        end else begin
            o_rec.mask[tce_pkg::SLOT_VEL_CODE] = w_vel_out;
            o_rec.mask[tce_pkg::SLOT_VEL_VAL]  = w_vel_out;
            o_rec.mask[tce_pkg::SLOT_ROT_CODE] = w_rot_out;
            o_rec.mask[tce_pkg::SLOT_ROT_VAL]  = w_rot_out;
            o_rec.mask[tce_pkg::SLOT_HALT]     = !w_moving && (r_drive == tce_pkg::DRIVE_MOVING);
        end
        o_rec.mask[tce_pkg::SLOT_BEAM] = (r_beam == tce_pkg::BEAM_DOWN_WAIT)
            || (r_beam == tce_pkg::BEAM_UP_WAIT)
            || ((r_beam == tce_pkg::BEAM_DOWN_ACKED) && i_button_released)
            || ((r_beam == tce_pkg::BEAM_UP_ACKED) && !i_button_released);
        o_rec.beam_off = (r_beam == tce_pkg::BEAM_UP_WAIT) || (r_beam == tce_pkg::BEAM_DOWN_ACKED);
    end

    assign o_push  = i_accept && !i_action && (o_rec.mask != '0);
    assign o_drive = r_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive <= tce_pkg::DRIVE_STOPPED;
            r_beam  <= tce_pkg::BEAM_UP_ACKED;
        end else begin
            r_drive <= n_drive;
            r_beam  <= n_beam;
        end
    end

endmodule

FILE: hdl/tce_queue.sv
module tce_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tce_pkg::t_rec i_rec,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output tce_pkg::t_rec o_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tce_pkg::t_rec r_mem [DEPTH];

    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= wrap_inc(r_wr);
            if (i_pop)  r_rd <= wrap_inc(r_rd);
            if (i_push && !i_pop)      r_count <= r_count + CNT_W'(1);
            else if (!i_push && i_pop) r_count <= r_count - CNT_W'(1);
        end
    end

endmodule

FILE: hdl/tce_back.sv
module tce_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  tce_pkg::t_rec   i_q_rec,
    input  tce_pkg::t_codes i_codes,
    input  logic            i_stall,
    output logic            o_pop,
    output logic            o_valid,
    output logic [7:0]      o_tx_byte,
    output logic            o_last_of_run
);

    logic [tce_pkg::NUM_SLOTS-1:0] r_mask;
    logic [7:0]                    r_pan, r_tilt, r_vel, r_rot;
    logic                          r_beam_off;
    logic                          r_valid;
    logic [7:0]                    r_tx;
    logic                          r_last;

    logic [tce_pkg::NUM_SLOTS-1:0] w_first, w_remain;
    logic [7:0]                    w_slot [tce_pkg::NUM_SLOTS];
    logic [7:0]                    w_byte;
    logic                          w_out_free, w_emit;

    assign w_out_free = !r_valid || !i_stall;
    assign w_emit     = w_out_free && (r_mask != '0);
    assign w_first    = r_mask & (~r_mask + tce_pkg::NUM_SLOTS'(1));
    assign w_remain   = r_mask & ~w_first;
    assign o_pop      = i_q_valid && ((r_mask == '0) || (w_emit && (w_remain == '0)));

    always_comb begin
        w_slot[tce_pkg::SLOT_PAN_CODE]  = i_codes.pan;
        w_slot[tce_pkg::SLOT_PAN_VAL]   = r_pan;
        w_slot[tce_pkg::SLOT_TILT_CODE] = i_codes.tilt;
        w_slot[tce_pkg::SLOT_TILT_VAL]  = r_tilt;
        w_slot[tce_pkg::SLOT_VEL_CODE]  = i_codes.vel;
        w_slot[tce_pkg::SLOT_VEL_VAL]   = r_vel;
        w_slot[tce_pkg::SLOT_ROT_CODE]  = i_codes.rot;
        w_slot[tce_pkg::SLOT_ROT_VAL]   = r_rot;
        w_slot[tce_pkg::SLOT_HALT]      = i_codes.halt;
        w_slot[tce_pkg::SLOT_BEAM]      = r_beam_off ? i_codes.beam_off : i_codes.beam_on;
    end

    // one-hot select of the lowest pending slot
    always_comb begin
        w_byte = '0;
        for (int k = 0; k < tce_pkg::NUM_SLOTS; k++) begin
            w_byte = w_byte | (w_slot[k] & {8{w_first[k]}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pan      <= i_q_rec.pan;
            r_tilt     <= i_q_rec.tilt;
            r_vel      <= i_q_rec.vel;
            r_rot      <= i_q_rec.rot;
            r_beam_off <= i_q_rec.beam_off;
        end
        if (w_emit) begin
            r_tx   <= w_byte;
            r_last <= (w_remain == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop)       r_mask <= i_q_rec.mask;
            else if (w_emit) r_mask <= w_remain;
            if (w_out_free)  r_valid <= w_emit;
        end
    end

    assign o_valid       = r_valid;
    assign o_tx_byte     = r_tx;
    assign o_last_of_run = r_last;

endmodule
